[sv/lahm_pkg.sv]
// Shared types and codes for the level alarm hysteresis monitor.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps

package lahm_pkg;

  // Default sample width (Q16.16)
  localparam int unsigned VALUE_WIDTH_DEF = 32;
  localparam int unsigned HYST_W          = 31;
  localparam int unsigned SEV_W           = 2;
  localparam int unsigned STA_W           = 3;
  localparam int unsigned LVL_SEVS_W      = 8;
  localparam int unsigned NUM_LEVELS      = 4;
  localparam int unsigned CFG_IDX_W       = 3;

  // Severity codes
  localparam logic [SEV_W-1:0] SEV_NONE    = 2'd0;
  localparam logic [SEV_W-1:0] SEV_MINOR   = 2'd1;
  localparam logic [SEV_W-1:0] SEV_MAJOR   = 2'd2;
  localparam logic [SEV_W-1:0] SEV_INVALID = 2'd3;

  // Status codes; the level codes follow the check order hihi, lolo, high, low
  localparam logic [STA_W-1:0] STA_NONE     = 3'd0;
  localparam logic [STA_W-1:0] STA_HIHI     = 3'd1;
  localparam logic [STA_W-1:0] STA_LOLO     = 3'd2;
  localparam logic [STA_W-1:0] STA_HIGH     = 3'd3;
  localparam logic [STA_W-1:0] STA_LOW      = 3'd4;
  localparam logic [STA_W-1:0] STA_UNDEF    = 3'd5;
  localparam logic [STA_W-1:0] STA_EXTERNAL = 3'd6;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MAJOR_HIGH = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MINOR_HIGH = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MINOR_LOW  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAJOR_LOW  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_HYSTERESIS = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_SEVS = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_VALUE_DB   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_ARCHIVE_DB = 3'd7;

  // Alarm part of one result beat
  typedef struct packed {
    logic [STA_W-1:0] status;
    logic [SEV_W-1:0] severity;
    logic             alarm_event;
  } alarm_res_t;

endpackage

[sv/lahm_if.sv]
// Sample and result channel interfaces of the level alarm monitor.
// Depends on lahm_pkg for the field widths.
`timescale 1ns / 1ps

interface lahm_smp_if import lahm_pkg::*; #(
  parameter int unsigned VW = VALUE_WIDTH_DEF
);
  logic                 valid;
  logic                 ready;
  logic signed [VW-1:0] sample_value;
  logic                 value_undefined;
  logic [SEV_W-1:0]     pending_severity;
  logic [STA_W-1:0]     pending_status;

  modport source (
    output valid, sample_value, value_undefined, pending_severity, pending_status,
    input  ready
  );
  modport sink (
    input  valid, sample_value, value_undefined, pending_severity, pending_status,
    output ready
  );
endinterface

interface lahm_res_if import lahm_pkg::*;;
  logic             valid;
  logic             ready;
  logic [STA_W-1:0] alarm_status;
  logic [SEV_W-1:0] alarm_severity;
  logic             value_event;
  logic             archive_event;
  logic             alarm_event;

  modport source (
    output valid, alarm_status, alarm_severity, value_event, archive_event, alarm_event,
    input  ready
  );
  modport sink (
    input  valid, alarm_status, alarm_severity, value_event, archive_event, alarm_event,
    output ready
  );
endinterface

[sv/lahm_cfg.sv]
// Configuration register file of the level alarm monitor.
// Depends on lahm_pkg for register indexes and widths.
`timescale 1ns / 1ps

module lahm_cfg import lahm_pkg::*; #(
  parameter int unsigned VW = VALUE_WIDTH_DEF,
  parameter int unsigned CW = (VW > HYST_W) ? VW : HYST_W
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [CW-1:0]          cfg_data_i,
  output logic signed [VW-1:0]   major_high_o,
  output logic signed [VW-1:0]   minor_high_o,
  output logic signed [VW-1:0]   minor_low_o,
  output logic signed [VW-1:0]   major_low_o,
  output logic [HYST_W-1:0]      hyst_o,
  output logic [LVL_SEVS_W-1:0]  lvl_sevs_o,
  output logic signed [VW-1:0]   value_db_o,
  output logic signed [VW-1:0]   archive_db_o
);

  logic signed [VW-1:0]  major_high_q, minor_high_q, minor_low_q, major_low_q;
  logic signed [VW-1:0]  value_db_q, archive_db_q;
  logic [HYST_W-1:0]     hyst_q;
  logic [LVL_SEVS_W-1:0] lvl_sevs_q;

  // Write one register per enabled cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      major_high_q <= '0;
      minor_high_q <= '0;
      minor_low_q  <= '0;
      major_low_q  <= '0;
      hyst_q       <= '0;
      lvl_sevs_q   <= '0;
      value_db_q   <= '0;
      archive_db_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_MAJOR_HIGH: major_high_q <= cfg_data_i[VW-1:0];
        CFG_MINOR_HIGH: minor_high_q <= cfg_data_i[VW-1:0];
        CFG_MINOR_LOW:  minor_low_q  <= cfg_data_i[VW-1:0];
        CFG_MAJOR_LOW:  major_low_q  <= cfg_data_i[VW-1:0];
        CFG_HYSTERESIS: hyst_q       <= cfg_data_i[HYST_W-1:0];
        CFG_LEVEL_SEVS: lvl_sevs_q   <= cfg_data_i[LVL_SEVS_W-1:0];
        CFG_VALUE_DB:   value_db_q   <= cfg_data_i[VW-1:0];
        CFG_ARCHIVE_DB: archive_db_q <= cfg_data_i[VW-1:0];
        default: ;
      endcase
    end
  end

  assign major_high_o = major_high_q;
  assign minor_high_o = minor_high_q;
  assign minor_low_o  = minor_low_q;
  assign major_low_o  = major_low_q;
  assign hyst_o       = hyst_q;
  assign lvl_sevs_o   = lvl_sevs_q;
  assign value_db_o   = value_db_q;
  assign archive_db_o = archive_db_q;

endmodule

[sv/lahm_alarm.sv]
// Four-level alarm check with hysteresis, plus alarm-change detection.
// Holds the last alarm level and previous status/severity; depends on lahm_pkg.
`timescale 1ns / 1ps

module lahm_alarm import lahm_pkg::*; #(
  parameter int unsigned VW = VALUE_WIDTH_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  adv_i,
  input  logic signed [VW-1:0]  sample_i,
  input  logic                  undef_i,
  input  logic [SEV_W-1:0]      pend_sev_i,
  input  logic [STA_W-1:0]      pend_sta_i,
  input  logic signed [VW-1:0]  major_high_i,
  input  logic signed [VW-1:0]  minor_high_i,
  input  logic signed [VW-1:0]  minor_low_i,
  input  logic signed [VW-1:0]  major_low_i,
  input  logic [HYST_W-1:0]     hyst_i,
  input  logic [LVL_SEVS_W-1:0] lvl_sevs_i,
  output alarm_res_t            res_o
);

  // Wide enough that limit +/- hysteresis never wraps
  localparam int unsigned EW = ((VW > HYST_W) ? VW : HYST_W) + 2;

  logic signed [VW-1:0] last_lvl_q, last_lvl_d;
  logic [SEV_W-1:0]     prev_sev_q;
  logic [STA_W-1:0]     prev_sta_q;

  logic signed [VW-1:0] lim [NUM_LEVELS];
  logic                 up  [NUM_LEVELS];
  logic [NUM_LEVELS-1:0] match;
  logic signed [EW-1:0] val_x, hyst_x;
  logic signed [EW-1:0] lim_x [NUM_LEVELS];
  logic signed [EW-1:0] bnd_x [NUM_LEVELS];

  logic                 hit;
  logic signed [VW-1:0] hit_lim;
  logic [SEV_W-1:0]     hit_sev;
  logic [STA_W-1:0]     hit_sta;
  logic [SEV_W-1:0]     sev;
  logic [STA_W-1:0]     sta;

  // Levels in check order: hihi, lolo, high, low
  assign lim[0] = major_high_i;
  assign lim[1] = major_low_i;
  assign lim[2] = minor_high_i;
  assign lim[3] = minor_low_i;
  assign up[0]  = 1'b1;
  assign up[1]  = 1'b0;
  assign up[2]  = 1'b1;
  assign up[3]  = 1'b0;

  assign val_x  = {{(EW-VW){sample_i[VW-1]}}, sample_i};
  assign hyst_x = {{(EW-HYST_W){1'b0}}, hyst_i};

  // Compare the sample against every level in parallel
  always_comb begin
    for (int i = 0; i < NUM_LEVELS; i++) begin
      lim_x[i] = {{(EW-VW){lim[i][VW-1]}}, lim[i]};
      bnd_x[i] = up[i] ? (lim_x[i] - hyst_x) : (lim_x[i] + hyst_x);
      if (up[i]) begin
        match[i] = (lvl_sevs_i[2*i +: SEV_W] != SEV_NONE) &&
                   ((val_x >= lim_x[i]) || ((last_lvl_q == lim[i]) && (val_x >= bnd_x[i])));
      end else begin
        match[i] = (lvl_sevs_i[2*i +: SEV_W] != SEV_NONE) &&
                   ((val_x <= lim_x[i]) || ((last_lvl_q == lim[i]) && (val_x <= bnd_x[i])));
      end
    end
  end

  // Pick the first matching level
  always_comb begin
    hit     = 1'b0;
    hit_lim = '0;
    hit_sev = SEV_NONE;
    hit_sta = STA_NONE;
    for (int i = NUM_LEVELS - 1; i >= 0; i--) begin
      if (match[i]) begin
        hit     = 1'b1;
        hit_lim = lim[i];
        hit_sev = lvl_sevs_i[2*i +: SEV_W];
        hit_sta = STA_W'(i + 1);
      end
    end
  end

  // Resolve final status/severity and the next last alarm level
  always_comb begin
    sev        = pend_sev_i;
    sta        = pend_sta_i;
    last_lvl_d = last_lvl_q;
    if (undef_i) begin
      if (pend_sev_i != SEV_INVALID) begin
        sev = SEV_INVALID;
        sta = STA_UNDEF;
      end
    end else if (hit) begin
      if (hit_sev > pend_sev_i) begin
        sev        = hit_sev;
        sta        = hit_sta;
        last_lvl_d = hit_lim;
      end
    end else begin
      last_lvl_d = sample_i;
    end
  end

  assign res_o.status      = sta;
  assign res_o.severity    = sev;
  assign res_o.alarm_event = (sev != prev_sev_q) || (sta != prev_sta_q);

  // Commit state when the beat moves to the result stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_lvl_q <= '0;
      prev_sev_q <= SEV_NONE;
      prev_sta_q <= STA_NONE;
    end else if (adv_i) begin
      last_lvl_q <= last_lvl_d;
      prev_sev_q <= sev;
      prev_sta_q <= sta;
    end
  end

endmodule

[sv/lahm_dband.sv]
// Deadband event check against a kept last value.
// Used for both the value and archive events; depends on lahm_pkg.
`timescale 1ns / 1ps

module lahm_dband import lahm_pkg::*; #(
  parameter int unsigned VW = VALUE_WIDTH_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 adv_i,
  input  logic signed [VW-1:0] sample_i,
  input  logic signed [VW-1:0] band_i,
  output logic                 event_o
);

  logic signed [VW-1:0] last_q;
  logic signed [VW:0]   diff;
  logic [VW:0]          mag;

  // Absolute difference, one bit wider so it never wraps
  assign diff = {last_q[VW-1], last_q} - {sample_i[VW-1], sample_i};
  assign mag  = diff[VW] ? (~diff + 1'b1) : diff;

  // A negative band always flags
  assign event_o = band_i[VW-1] || (mag > {1'b0, band_i});

  // Take the sample as the new reference when an event is flagged
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q <= '0;
    end else if (adv_i && event_o) begin
      last_q <= sample_i;
    end
  end

endmodule

[sv/level_alarm_hysteresis_monitor_core.sv]
// Top level of the level alarm hysteresis monitor.
// Depends on lahm_pkg, lahm_if, lahm_cfg, lahm_alarm and lahm_dband.
//
// Usage:
//   smp_i carries one sample beat: value, undefined flag, pending severity
//   and pending status. res_o carries one result beat per sample: status,
//   severity and the value, archive and alarm event flags.
//   Configuration is a write-only port (cfg_we_i, cfg_idx_i, cfg_data_i);
//   write it only while no sample is in flight.
//   Path: a sample accepted into the sample register moves to the result
//   register when the result stage is empty or being drained, and shows on
//   res_o from the result register until it is taken.
//   Throughput: one beat per cycle while res_o.ready is high, set by a
//   single pass through the level compares and deadband subtracts between
//   the sample and result registers; the result load also commits kept state.
//   Stall: when res_o.ready is low the result holds, the sample register
//   still takes one more beat, and smp_i.ready drops once both are full.
//   Reset: all configuration registers, last values and previous
//   status/severity clear to zero and both stages empty; no clearing pass.
`timescale 1ns / 1ps

module level_alarm_hysteresis_monitor_core import lahm_pkg::*; #(
  parameter int unsigned VALUE_WIDTH = VALUE_WIDTH_DEF,
  parameter int unsigned CFG_W       = (VALUE_WIDTH > HYST_W) ? VALUE_WIDTH : HYST_W
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  lahm_smp_if.sink            smp_i,
  lahm_res_if.source          res_o,
  input  logic                cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]    cfg_data_i
);

  localparam int unsigned VW = VALUE_WIDTH;

  logic signed [VW-1:0]  major_high, minor_high, minor_low, major_low;
  logic signed [VW-1:0]  value_db, archive_db;
  logic [HYST_W-1:0]     hyst;
  logic [LVL_SEVS_W-1:0] lvl_sevs;

  logic                 in_vld_q;
  logic signed [VW-1:0] in_val_q;
  logic                 in_und_q;
  logic [SEV_W-1:0]     in_sev_q;
  logic [STA_W-1:0]     in_sta_q;

  logic                 out_vld_q;
  alarm_res_t           alm_res, alm_res_q;
  logic                 val_evt, arc_evt, val_evt_q, arc_evt_q;

  logic                 adv, in_fire;

  lahm_cfg #(.VW(VW), .CW(CFG_W)) u_cfg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .major_high_o (major_high),
    .minor_high_o (minor_high),
    .minor_low_o  (minor_low),
    .major_low_o  (major_low),
    .hyst_o       (hyst),
    .lvl_sevs_o   (lvl_sevs),
    .value_db_o   (value_db),
    .archive_db_o (archive_db)
  );

  // Move a beat forward when the result stage is empty or being drained
  assign adv         = in_vld_q && (!out_vld_q || res_o.ready);
  assign smp_i.ready = !in_vld_q || adv;
  assign in_fire     = smp_i.valid && smp_i.ready;

  // Sample register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_fire) begin
      in_vld_q <= 1'b1;
    end else if (adv) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      in_val_q <= smp_i.sample_value;
      in_und_q <= smp_i.value_undefined;
      in_sev_q <= smp_i.pending_severity;
      in_sta_q <= smp_i.pending_status;
    end
  end

  lahm_alarm #(.VW(VW)) u_alarm (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .adv_i        (adv),
    .sample_i     (in_val_q),
    .undef_i      (in_und_q),
    .pend_sev_i   (in_sev_q),
    .pend_sta_i   (in_sta_q),
    .major_high_i (major_high),
    .minor_high_i (minor_high),
    .minor_low_i  (minor_low),
    .major_low_i  (major_low),
    .hyst_i       (hyst),
    .lvl_sevs_i   (lvl_sevs),
    .res_o        (alm_res)
  );

  lahm_dband #(.VW(VW)) u_val_db (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .adv_i    (adv),
    .sample_i (in_val_q),
    .band_i   (value_db),
    .event_o  (val_evt)
  );

  lahm_dband #(.VW(VW)) u_arc_db (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .adv_i    (adv),
    .sample_i (in_val_q),
    .band_i   (archive_db),
    .event_o  (arc_evt)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= 1'b1;
    end else if (res_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      alm_res_q <= alm_res;
      val_evt_q <= val_evt;
      arc_evt_q <= arc_evt;
    end
  end

  assign res_o.valid          = out_vld_q;
  assign res_o.alarm_status   = alm_res_q.status;
  assign res_o.alarm_severity = alm_res_q.severity;
  assign res_o.alarm_event    = alm_res_q.alarm_event;
  assign res_o.value_event    = val_evt_q;
  assign res_o.archive_event  = arc_evt_q;

  // A beat that advances is always presented next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni) adv |=> out_vld_q)
    else $error("advanced beat not presented");

  // Final severity never drops below the pending severity
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv |=> (alm_res_q.severity >= $past(in_sev_q)))
    else $error("severity below pending severity");

  // An undefined sample ends at severity invalid
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && in_und_q) |=> (alm_res_q.severity == SEV_INVALID))
    else $error("undefined sample not invalid");

  // An empty sample register always takes a beat
  assert property (@(posedge clk_i) disable iff (!rst_ni) !in_vld_q |-> smp_i.ready)
    else $error("sample stage empty but not ready");

endmodule

[test/tb_level_alarm_hysteresis_monitor_core.sv]
// Self-checking testbench for level_alarm_hysteresis_monitor_core: random idling on
// both channels, a built-in alarm/deadband predictor, and a field-by-field result check.
// Depends on lahm_pkg, lahm_if and the core RTL.
`timescale 1ns / 1ps

module tb_level_alarm_hysteresis_monitor_core;
  import lahm_pkg::*;

  localparam int     VW             = VALUE_WIDTH_DEF;
  localparam int     WATCHDOG_LIMIT = 2000;
  localparam int     ITEMS_PER_SET  = 96;
  localparam longint VMAX           = (longint'(1) << 31) - 1;
  localparam longint VMIN           = -(longint'(1) << 31);

  typedef struct {
    logic signed [VW-1:0] value;
    logic                 undefined;
    logic [SEV_W-1:0]     severity;
    logic [STA_W-1:0]     status;
  } smp_item_t;

  typedef struct {
    logic [STA_W-1:0] status;
    logic [SEV_W-1:0] severity;
    logic             value_event;
    logic             archive_event;
    logic             alarm_event;
  } alarm_result_t;

  logic           clk_i = 1'b0;
  logic           rst_ni;
  logic           cfg_we_i;
  logic [2:0]     cfg_idx_i;
  logic [VW-1:0]  cfg_data_i;

  lahm_smp_if #(.VW(VW)) smp_if ();
  lahm_res_if            res_if ();

  level_alarm_hysteresis_monitor_core DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .smp_i      (smp_if),
    .res_o      (res_if),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  always #10 clk_i = ~clk_i;

  // Register mirror, written from the config port as the block sees it
  logic signed [VW-1:0] level_lim [0:3];
  logic [HYST_W-1:0]    hyst_band;
  logic [7:0]           lvl_sevs;
  logic signed [VW-1:0] value_db;
  logic signed [VW-1:0] archive_db;

  // Kept alarm state of the predictor
  logic signed [VW-1:0] alarm_level;
  logic signed [VW-1:0] posted_value;
  logic signed [VW-1:0] archived_value;
  logic [SEV_W-1:0]     prev_sev;
  logic [STA_W-1:0]     prev_sta;

  smp_item_t     pending_samples[$];
  alarm_result_t expected_alarms[$];

  bit smp_beat, res_beat;
  int send_idle_pct, recv_idle_pct;
  int items_queued, results_checked, mismatch_count, quiet_cycles;
  int level_alarms, undefined_seen, value_events, archive_events, alarm_events;

  function automatic bit trips_high(longint v, longint lim, longint hy);
    return v >= lim || (longint'(alarm_level) == lim && v >= lim - hy);
  endfunction

  function automatic bit trips_low(longint v, longint lim, longint hy);
    return v <= lim || (longint'(alarm_level) == lim && v <= lim + hy);
  endfunction

  // Grade one sample: level checks with hysteresis, then deadbands; updates kept state
  function automatic alarm_result_t grade_sample(smp_item_t s);
    alarm_result_t    r;
    longint           v, lim, hy, gap;
    logic [SEV_W-1:0] sev, hit_sev;
    logic [STA_W-1:0] sta, hit_sta;
    logic             hit;
    v       = longint'(s.value);
    hy      = longint'(hyst_band);
    sev     = s.severity;
    sta     = s.status;
    hit     = 1'b1;
    lim     = 0;
    hit_sev = SEV_NONE;
    hit_sta = STA_NONE;
    if (s.undefined) begin
      if (sev != SEV_INVALID) begin
        sev = SEV_INVALID;
        sta = STA_UNDEF;
      end
    end else begin
      if (lvl_sevs[1:0] != SEV_NONE &&
          trips_high(v, longint'(level_lim[CFG_MAJOR_HIGH]), hy)) begin
        lim = longint'(level_lim[CFG_MAJOR_HIGH]); hit_sev = lvl_sevs[1:0]; hit_sta = STA_HIHI;
      end else if (lvl_sevs[3:2] != SEV_NONE &&
                   trips_low(v, longint'(level_lim[CFG_MAJOR_LOW]), hy)) begin
        lim = longint'(level_lim[CFG_MAJOR_LOW]); hit_sev = lvl_sevs[3:2]; hit_sta = STA_LOLO;
      end else if (lvl_sevs[5:4] != SEV_NONE &&
                   trips_high(v, longint'(level_lim[CFG_MINOR_HIGH]), hy)) begin
        lim = longint'(level_lim[CFG_MINOR_HIGH]); hit_sev = lvl_sevs[5:4]; hit_sta = STA_HIGH;
      end else if (lvl_sevs[7:6] != SEV_NONE &&
                   trips_low(v, longint'(level_lim[CFG_MINOR_LOW]), hy)) begin
        lim = longint'(level_lim[CFG_MINOR_LOW]); hit_sev = lvl_sevs[7:6]; hit_sta = STA_LOW;
      end else begin
        hit = 1'b0;
      end
      // A raise only counts above the pending severity; out of alarm, track the value
      if (!hit) begin
        alarm_level = s.value;
      end else if (hit_sev > sev) begin
        sev         = hit_sev;
        sta         = hit_sta;
        alarm_level = VW'(lim);
      end
    end

    r.status      = sta;
    r.severity    = sev;
    r.alarm_event = (sev != prev_sev) || (sta != prev_sta);
    prev_sev      = sev;
    prev_sta      = sta;

    gap = longint'(posted_value) - v;
    if (gap < 0) gap = -gap;
    r.value_event = (value_db < 0) || (gap > value_db);
    if (r.value_event) posted_value = s.value;

    gap = longint'(archived_value) - v;
    if (gap < 0) gap = -gap;
    r.archive_event = (archive_db < 0) || (gap > archive_db);
    if (r.archive_event) archived_value = s.value;
    return r;
  endfunction

  // Feed sample beats from the pending queue, with random gaps
  always @(negedge clk_i) begin : drive_samples
    smp_item_t nxt;
    if (rst_ni && (!smp_if.valid || smp_beat)) begin
      if (pending_samples.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
        nxt                     = pending_samples.pop_front();
        smp_if.valid            <= 1'b1;
        smp_if.sample_value     <= nxt.value;
        smp_if.value_undefined  <= nxt.undefined;
        smp_if.pending_severity <= nxt.severity;
        smp_if.pending_status   <= nxt.status;
      end else begin
        smp_if.valid <= 1'b0;
      end
    end
    res_if.ready <= rst_ni && ($urandom_range(99, 0) >= recv_idle_pct);
  end

  // Watch both channels: mirror config, check results, predict accepted samples
  always @(posedge clk_i) begin : watch_beats
    alarm_result_t want, got;
    smp_item_t     s;
    smp_beat = smp_if.valid && smp_if.ready;
    res_beat = res_if.valid && res_if.ready;
    if (!rst_ni) begin
      foreach (level_lim[i]) level_lim[i] = '0;
      hyst_band      = '0;
      lvl_sevs       = '0;
      value_db       = '0;
      archive_db     = '0;
      alarm_level    = '0;
      posted_value   = '0;
      archived_value = '0;
      prev_sev       = SEV_NONE;
      prev_sta       = STA_NONE;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_MAJOR_HIGH, CFG_MINOR_HIGH,
          CFG_MINOR_LOW, CFG_MAJOR_LOW: level_lim[cfg_idx_i] = cfg_data_i;
          CFG_HYSTERESIS:               hyst_band  = cfg_data_i[HYST_W-1:0];
          CFG_LEVEL_SEVS:               lvl_sevs   = cfg_data_i[7:0];
          CFG_VALUE_DB:                 value_db   = cfg_data_i;
          CFG_ARCHIVE_DB:               archive_db = cfg_data_i;
          default: ;
        endcase
      end

      // Check the result beat against the oldest expectation
      if (res_beat) begin
        got.status        = res_if.alarm_status;
        got.severity      = res_if.alarm_severity;
        got.value_event   = res_if.value_event;
        got.archive_event = res_if.archive_event;
        got.alarm_event   = res_if.alarm_event;
        results_checked++;
        if (expected_alarms.size() == 0) begin
          $error("result beat with no sample outstanding: alarm_status %0d", got.status);
          mismatch_count++;
        end else begin
          want = expected_alarms.pop_front();
          if (got.status !== want.status) begin
            $error("alarm_status: expected %0d, got %0d", want.status, got.status);
            mismatch_count++;
          end
          if (got.severity !== want.severity) begin
            $error("alarm_severity: expected %0d, got %0d", want.severity, got.severity);
            mismatch_count++;
          end
          if (got.value_event !== want.value_event) begin
            $error("value_event: expected %0b, got %0b", want.value_event, got.value_event);
            mismatch_count++;
          end
          if (got.archive_event !== want.archive_event) begin
            $error("archive_event: expected %0b, got %0b",
                   want.archive_event, got.archive_event);
            mismatch_count++;
          end
          if (got.alarm_event !== want.alarm_event) begin
            $error("alarm_event: expected %0b, got %0b", want.alarm_event, got.alarm_event);
            mismatch_count++;
          end
          if (want.status inside {STA_HIHI, STA_LOLO, STA_HIGH, STA_LOW}) level_alarms++;
          if (want.status == STA_UNDEF) undefined_seen++;
          value_events   += want.value_event;
          archive_events += want.archive_event;
          alarm_events   += want.alarm_event;
        end
      end

      if (smp_beat) begin
        s.value     = smp_if.sample_value;
        s.undefined = smp_if.value_undefined;
        s.severity  = smp_if.pending_severity;
        s.status    = smp_if.pending_status;
        expected_alarms.push_back(grade_sample(s));
      end

      // Stop a hung run
      quiet_cycles = (smp_beat || res_beat) ? 0 : quiet_cycles + 1;
      if (quiet_cycles == WATCHDOG_LIMIT) begin
        $display("Timeout: no beat for %0d cycles", WATCHDOG_LIMIT);
        $display("Mismatches found");
        $finish;
      end
    end
  end

  function automatic logic signed [VW-1:0] q16(int whole);
    return whole * 65536;
  endfunction

  task automatic queue_sample(input logic signed [VW-1:0] v, input logic u,
                              input logic [SEV_W-1:0] sv, input logic [STA_W-1:0] st);
    smp_item_t it;
    it.value     = v;
    it.undefined = u;
    it.severity  = sv;
    it.status    = st;
    pending_samples.push_back(it);
    items_queued++;
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [VW-1:0] data);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
  endtask

  task automatic program_regs(input logic [VW-1:0] hihi, high, low, lolo, hyst,
                              input logic [7:0] sevs, input logic [VW-1:0] vdb, adb);
    write_reg(CFG_MAJOR_HIGH, hihi);
    write_reg(CFG_MINOR_HIGH, high);
    write_reg(CFG_MINOR_LOW, low);
    write_reg(CFG_MAJOR_LOW, lolo);
    write_reg(CFG_HYSTERESIS, hyst);
    write_reg(CFG_LEVEL_SEVS, {24'd0, sevs});
    write_reg(CFG_VALUE_DB, vdb);
    write_reg(CFG_ARCHIVE_DB, adb);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Mostly ordered limits around a random center; sometimes scrambled
  task automatic program_random_regs();
    longint      c, g;
    logic [VW-1:0] lims [4];
    int          vdb, adb;
    c = (longint'($urandom_range(2000, 0)) - 1000) * 65536;
    g = longint'($urandom_range(40, 1)) * 65536;
    if ($urandom_range(3, 0) == 0) begin
      foreach (lims[i]) lims[i] = $urandom();
    end else begin
      lims[0] = VW'(c + 2 * g);
      lims[1] = VW'(c + g);
      lims[2] = VW'(c - g);
      lims[3] = VW'(c - 2 * g);
    end
    vdb = ($urandom_range(9, 0) == 0) ? -int'($urandom_range(1000, 1))
                                      : int'($urandom_range(3 * 65536, 0));
    adb = ($urandom_range(9, 0) == 0) ? -int'($urandom_range(1000, 1))
                                      : int'($urandom_range(8 * 65536, 0));
    program_regs(lims[0], lims[1], lims[2], lims[3], $urandom_range(6 * 65536, 0),
                 8'($urandom_range(255, 0)), vdb, adb);
  endtask

  // Random walks near the limits, with jumps, extremes and undefined samples mixed in
  task automatic queue_random(input int n);
    longint           walk, span;
    logic [SEV_W-1:0] sv;
    logic [STA_W-1:0] st;
    int               pick;
    walk = 0;
    span = (hyst_band > (1 << 22)) ? (1 << 22) : longint'(hyst_band);
    span = span + 2 * 65536;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(99, 0);
      if (pick < 50) begin
        walk = walk + longint'($urandom_range(32'(2 * span), 0)) - span;
      end else if (pick < 85) begin
        walk = longint'(level_lim[$urandom_range(3, 0)]) +
               longint'($urandom_range(32'(2 * span), 0)) - span;
      end else if (pick < 95) begin
        walk = longint'($signed($urandom()));
      end else begin
        case ($urandom_range(3, 0))
          0:       walk = VMAX;
          1:       walk = VMIN;
          2:       walk = 0;
          default: walk = -1;
        endcase
      end
      if (walk > VMAX) walk = VMAX;
      if (walk < VMIN) walk = VMIN;
      sv = ($urandom_range(9, 0) < 6) ? SEV_NONE : SEV_W'($urandom_range(3, 0));
      st = (sv == SEV_NONE && $urandom_range(3, 0) != 0) ? STA_NONE
                                                         : STA_W'($urandom_range(7, 0));
      queue_sample(VW'(walk), $urandom_range(19, 0) == 0, sv, st);
    end
  endtask

  task automatic wait_drained();
    while (results_checked < items_queued) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  initial begin
    rst_ni                  = 1'b0;
    cfg_we_i                = 1'b0;
    cfg_idx_i               = CFG_MAJOR_HIGH;
    cfg_data_i              = '0;
    smp_if.valid            = 1'b0;
    smp_if.sample_value     = '0;
    smp_if.value_undefined  = 1'b0;
    smp_if.pending_severity = SEV_NONE;
    smp_if.pending_status   = STA_NONE;
    res_if.ready            = 1'b0;
    send_idle_pct           = 34;
    recv_idle_pct           = 72;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Ordered limits +/-100 and +/-50 with a 5.0 band; majors outer, minors inner
    program_regs(q16(100), q16(50), q16(-50), q16(-100), q16(5), 8'h5A, q16(1), q16(10));
    queue_sample(q16(0), 1'b0, SEV_NONE, STA_NONE);
    queue_sample(q16(100), 1'b0, SEV_NONE, STA_NONE);       // hihi on the limit
    queue_sample(q16(97), 1'b0, SEV_NONE, STA_NONE);        // held by hysteresis
    queue_sample(q16(94), 1'b0, SEV_NONE, STA_NONE);        // drop to high
    queue_sample(q16(46), 1'b0, SEV_NONE, STA_NONE);        // high held
    queue_sample(q16(44), 1'b0, SEV_NONE, STA_NONE);        // clear
    queue_sample(q16(-100), 1'b0, SEV_NONE, STA_NONE);      // lolo
    queue_sample(q16(-96), 1'b0, SEV_NONE, STA_NONE);
    queue_sample(q16(-94), 1'b0, SEV_NONE, STA_NONE);       // drop to low
    queue_sample(q16(-46), 1'b0, SEV_NONE, STA_NONE);
    queue_sample(q16(0), 1'b0, SEV_NONE, STA_NONE);
    queue_sample(32'h7FFF_FFFF, 1'b0, SEV_NONE, STA_NONE);
    queue_sample(32'h8000_0000, 1'b0, SEV_NONE, STA_NONE);
    queue_sample(q16(0), 1'b1, SEV_NONE, STA_NONE);         // undefined
    queue_sample(q16(200), 1'b1, SEV_INVALID, STA_EXTERNAL);
    queue_sample(q16(150), 1'b0, SEV_MAJOR, STA_EXTERNAL);  // raise not higher
    queue_sample(q16(150), 1'b0, SEV_MINOR, STA_EXTERNAL);  // raise wins
    queue_sample(q16(20), 1'b0, SEV_NONE, 3'd7);            // odd status passes
    queue_sample(q16(60), 1'b0, SEV_MINOR, STA_HIGH);
    queue_sample(q16(60), 1'b0, SEV_NONE, STA_NONE);
    queue_sample(q16(0), 1'b0, SEV_INVALID, STA_LOW);
    queue_sample(32'sh0000_0001, 1'b0, SEV_NONE, STA_NONE); // inside value deadband
    queue_sample(32'sh0001_0002, 1'b0, SEV_NONE, STA_NONE); // just past it
    queue_random(ITEMS_PER_SET);
    wait_drained();

    // Limits at the number range, widest band, all invalid, one negative deadband
    program_regs(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                 32'h7FFF_FFFF, 8'hFF, 32'h7FFF_FFFF, 32'h8000_0000);
    queue_random(ITEMS_PER_SET);
    wait_drained();

    // Everything cleared: no level is checked
    send_idle_pct = 72;
    recv_idle_pct = 34;
    program_regs('0, '0, '0, '0, '0, 8'h00, '0, '0);
    queue_random(ITEMS_PER_SET);
    wait_drained();

    program_random_regs();
    queue_random(ITEMS_PER_SET);
    wait_drained();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (2) begin
      program_random_regs();
      queue_random(ITEMS_PER_SET);
      wait_drained();
    end

    if (expected_alarms.size() != 0) begin
      $error("%0d expected results never arrived", expected_alarms.size());
      mismatch_count++;
    end
    $display("Checked %0d results over six register settings: %0d level alarms, %0d undefined",
             results_checked, level_alarms, undefined_seen);
    $display("Flags raised: %0d value, %0d archive, %0d alarm",
             value_events, archive_events, alarm_events);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
